// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
// Each expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- rtl/tgr_pkg.sv -----
package tgr_pkg;

  // Font geometry
  localparam int GLYPH_ROWS    = 16;
  localparam int GLYPH_COLUMNS = 8;
  localparam int GLYPH_COUNT   = 95;
  localparam int FONT_DEPTH    = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);
  localparam int ROW_W         = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  // Queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Request opcodes
  localparam logic OP_RENDER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Result kinds
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LINE_PITCH    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FG_COLOR      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BG_COLOR      = 3'd4;

  // Register reset values
  localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd640;
  localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;
  localparam logic [12:0] RST_LINE_PITCH    = 13'd640;
  localparam logic [31:0] RST_FG_COLOR      = 32'd16571628;
  localparam logic [31:0] RST_BG_COLOR      = 32'd1579040;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [12:0] line_pitch;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  char_code;
    logic [10:0] font_index;
    logic [7:0]  font_byte;
  } in_req_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] word_address;
    logic [7:0]  pixel_mask;
    logic [31:0] color;
    logic        last;
  } out_res_t;

  // Classified work passed from front to back
  typedef struct packed {
    logic               is_load;
    logic               scroll;
    logic               draw;
    logic [11:0]        x;
    logic [FONT_AW-1:0] addr;
    logic [7:0]         data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_link_t;

endpackage

// ----- rtl/tgr_ram.sv -----
module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1520
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tgr_front.sv -----
`include "assert_macros.svh"

module tgr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  tgr_pkg::in_req_t   in_data,
  input  tgr_pkg::cfg_t      cfg,
  output tgr_pkg::cmd_link_t link,
  input  logic               link_pop
);

  import tgr_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  logic [12:0]      cursor_r, cursor_nxt;
  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic        accept;
  logic        is_cr, is_lf, printable, need_scroll, enq;
  logic [7:0]  ch_fix, glyph;
  logic [12:0] draw_x;
  logic        deq;
  cmd_t        cmd;

  assign full   = (count_r == CNT_W'(CMDQ_DEPTH));
  assign accept = push && !full;

  // Classify the request
  assign is_cr       = (in_data.char_code == CHAR_CR);
  assign is_lf       = (in_data.char_code == CHAR_LF);
  assign printable   = (in_data.char_code >= CHAR_SPACE) && (in_data.char_code <= CHAR_TILDE);
  assign ch_fix      = printable ? in_data.char_code : CHAR_QMARK;
  assign glyph       = ch_fix - CHAR_SPACE;
  assign need_scroll = {2'b00, cfg.screen_width} <
                       ({1'b0, cursor_r} + 14'(GLYPH_COLUMNS));
  assign draw_x      = need_scroll ? '0 : cursor_r;

  always_comb begin
    cmd         = '0;
    enq         = 1'b0;
    cursor_nxt  = cursor_r;
    if (in_data.opcode == OP_LOAD) begin
      cmd.is_load = 1'b1;
      cmd.addr    = FONT_AW'(in_data.font_index);
      cmd.data    = in_data.font_byte;
      enq         = (32'(in_data.font_index) < FONT_DEPTH);
    end else if (is_cr) begin
      cursor_nxt = '0;
    end else if (is_lf) begin
      cmd.scroll = 1'b1;
      enq        = 1'b1;
      cursor_nxt = '0;
    end else begin
      cmd.scroll = need_scroll;
      cmd.draw   = 1'b1;
      cmd.x      = draw_x[11:0];
      cmd.addr   = FONT_AW'(32'(glyph) * GLYPH_ROWS);
      enq        = 1'b1;
      cursor_nxt = draw_x + 13'(GLYPH_COLUMNS);
    end
  end

  // Update the cursor on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (accept) begin
      cursor_r <= cursor_nxt;
    end
  end

  // Command queue toward the back end
  assign deq = link_pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (accept && enq) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept && enq) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (deq) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(accept && enq) - CNT_W'(deq);
    end
  end

  assign link.valid = (count_r != '0);
  assign link.cmd   = mem_r[rd_ptr_r];

  // The cursor never passes the widest screen
  `ASSERT_NEVER(a_cursor_bound, cursor_r[12], "cursor beyond 4095")

endmodule

// ----- rtl/tgr_out_fifo.sv -----
`include "assert_macros.svh"

module tgr_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  tgr_pkg::out_res_t          wr_data,
  output logic                       empty,
  input  logic                       pop,
  output tgr_pkg::out_res_t          out_data,
  output logic [tgr_pkg::OUTQ_CNT_W-1:0] level
);

  import tgr_pkg::*;

  localparam int PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;

  out_res_t              mem_r [OUTQ_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0] count_r;
  logic                  deq;

  assign empty = (count_r == '0);
  assign deq   = pop && !empty;

  // Hold results until the consumer takes them
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (deq) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + OUTQ_CNT_W'(wr_en) - OUTQ_CNT_W'(deq);
    end
  end

  assign out_data = mem_r[rd_ptr_r];
  assign level    = count_r;

  // Credit logic upstream must never overrun the queue
  `ASSERT_NEVER(a_no_overflow, wr_en && (count_r == OUTQ_CNT_W'(OUTQ_DEPTH)),
    "result queue overflow")

endmodule

// ----- rtl/tgr_back.sv -----
`include "assert_macros.svh"

module tgr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tgr_pkg::cfg_t                  cfg,
  input  tgr_pkg::cmd_link_t             link,
  output logic                           link_pop,
  input  logic [tgr_pkg::OUTQ_CNT_W-1:0] out_level,
  output logic                           res_push,
  output tgr_pkg::out_res_t              res
);

  import tgr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCROLL = 3'b010,
    ST_ROWS   = 3'b100
  } bstate_t;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

  bstate_t            state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [11:0]        x_r, x_nxt;
  logic [FONT_AW-1:0] base_r, base_nxt;
  logic               draw_r, draw_nxt;

  logic        s1_valid_r;
  logic        s1_kind_r, s1_last_r;
  logic [11:0] s1_x_r, s1_y_r;

  logic               space, issue, take;
  logic [11:0]        y0;
  logic               iss_kind, iss_last;
  logic [11:0]        iss_x, iss_y;
  logic [FONT_AW-1:0] rd_addr;
  logic [7:0]         font_q;
  logic [24:0]        addr_sum;

  // Leave room in the result queue for the request in flight
  assign space = ({1'b0, out_level} + (OUTQ_CNT_W + 1)'(s1_valid_r)) <
                 (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
  assign issue = (state_r != ST_IDLE) && space;

  // Describe the next result
  assign y0       = (cfg.screen_height < 12'(GLYPH_ROWS)) ? '0 :
                    cfg.screen_height - 12'(GLYPH_ROWS);
  assign iss_kind = (state_r == ST_SCROLL) ? KIND_SCROLL : KIND_ROW;
  assign iss_x    = (state_r == ST_SCROLL) ? '0 : x_r;
  assign iss_y    = (state_r == ST_SCROLL) ? y0 : y0 + 12'(row_r);
  assign iss_last = (state_r == ST_SCROLL) ? !draw_r : (row_r == ROW_LAST);
  assign rd_addr  = base_r + FONT_AW'(row_r);

  // Take the next command when idle or on the final result
  assign take     = link.valid && ((state_r == ST_IDLE) || (issue && iss_last));
  assign link_pop = take;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    x_nxt     = x_r;
    base_nxt  = base_r;
    draw_nxt  = draw_r;
    if (take) begin
      if (link.cmd.is_load) begin
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = link.cmd.scroll ? ST_SCROLL : ST_ROWS;
        row_nxt   = '0;
        x_nxt     = link.cmd.x;
        base_nxt  = link.cmd.addr;
        draw_nxt  = link.cmd.draw;
      end
    end else if (issue) begin
      unique case (state_r)
        ST_SCROLL: begin
          state_nxt = draw_r ? ST_ROWS : ST_IDLE;
        end
        ST_ROWS: begin
          if (row_r == ROW_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    x_r    <= x_nxt;
    base_r <= base_nxt;
    draw_r <= draw_nxt;
  end

  // Font store: loads write here in queue order
  tgr_ram #(
    .WIDTH(8),
    .DEPTH(FONT_DEPTH)
  ) u_font (
    .clk  (clk),
    .we   (take && link.cmd.is_load),
    .waddr(link.cmd.addr),
    .wdata(link.cmd.data),
    .raddr(rd_addr),
    .rdata(font_q)
  );

  // Register the result descriptor alongside the font read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r <= iss_kind;
    s1_last_r <= iss_last;
    s1_x_r    <= iss_x;
    s1_y_r    <= iss_y;
  end

  // Form the word address and finish the result
  assign addr_sum = 25'(s1_y_r) * 25'(cfg.line_pitch) + 25'(s1_x_r);

  always_comb begin
    res.kind         = s1_kind_r;
    res.pixel_x      = s1_x_r;
    res.pixel_y      = s1_y_r;
    res.word_address = addr_sum[23:0];
    res.pixel_mask   = (s1_kind_r == KIND_SCROLL) ? '0 : font_q;
    res.color        = (s1_kind_r == KIND_SCROLL) ? cfg.bg_color : cfg.fg_color;
    res.last         = s1_last_r;
  end

  assign res_push = s1_valid_r;

  // A scroll ahead of a glyph hands over to the first row
  `ASSERT_CLK(a_scroll_then_rows,
    (state_r == ST_SCROLL) && issue && draw_r |=> (state_r == ST_ROWS) && (row_r == '0),
    "scroll did not lead into glyph rows")
  // The credit check keeps a slot for the result in flight
  `ASSERT_NEVER(a_credit, s1_valid_r && (out_level == OUTQ_CNT_W'(OUTQ_DEPTH)),
    "result issued without queue space")

endmodule

// ----- rtl/text_glyph_renderer.sv -----
// Text console renderer for 8-wide bitmap glyphs on the bottom text line. Each
// request is either a font byte load or a character; the block answers with
// framebuffer work: row writes (pixel column, line, word address, mask, color)
// and scroll commands. A drawn character yields 16 row writes, 17 when it
// wraps and scrolls first; a newline yields one scroll; a carriage return or a
// font load yields nothing. Results leave at one per cycle while the result
// queue has room, issued by the row sequencer with one font-store read each:
// a character holds the back end for its scroll and rows, a newline for its
// scroll, a font load while it is written, a carriage return not at all. An
// idle back end (also right after a font load) takes a command in before its
// first result issues; each result is registered with its font byte before
// it enters the result queue. A four-entry command queue takes requests on
// back-to-back cycles while earlier characters are still being drawn; full
// rises once four commands are waiting. Font entries must be loaded before
// they are drawn. Write configuration only while no request is outstanding.
`include "assert_macros.svh"

module text_glyph_renderer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  tgr_pkg::in_req_t                  in_data,
  output logic                              empty,
  input  logic                              pop,
  output tgr_pkg::out_res_t                 out_data,
  input  logic                              cfg_we,
  input  logic [tgr_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  import tgr_pkg::*;

  cfg_t                  cfg_r;
  cmd_link_t             link;
  logic                  link_pop;
  logic [OUTQ_CNT_W-1:0] out_level;
  logic                  res_push;
  out_res_t              res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
      cfg_r.line_pitch    <= RST_LINE_PITCH;
      cfg_r.fg_color      <= RST_FG_COLOR;
      cfg_r.bg_color      <= RST_BG_COLOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data[11:0];
        REG_LINE_PITCH:    cfg_r.line_pitch    <= cfg_data[12:0];
        REG_FG_COLOR:      cfg_r.fg_color      <= cfg_data;
        REG_BG_COLOR:      cfg_r.bg_color      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tgr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .cfg     (cfg_r),
    .link    (link),
    .link_pop(link_pop)
  );

  tgr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .link     (link),
    .link_pop (link_pop),
    .out_level(out_level),
    .res_push (res_push),
    .res      (res)
  );

  tgr_out_fifo u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .level   (out_level)
  );

  // The back end only pops commands the front has queued
  `ASSERT_NEVER(a_pop_valid, link_pop && !link.valid, "command popped from empty queue")

endmodule
